// File: rtl/core/hfdl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package hfdl_pkg;

   // store geometry; DEPTH is a power of two so positions wrap by truncation
   localparam int DEPTH  = 4096;
   localparam int AW     = $clog2(DEPTH);
   localparam int LANES  = 2;
   localparam int SMP_W  = 24;
   localparam int WORD_W = LANES * SMP_W;
   localparam int FRAC_W = 16;
   localparam int DLY_W  = 28;
   localparam int POS_W  = AW + FRAC_W;
   localparam int ACC_W  = 32;

   localparam logic [DLY_W-1:0] DLY_MIN = DLY_W'(2 << FRAC_W);
   localparam logic [DLY_W-1:0] DLY_MAX = DLY_W'((DEPTH - 4) << FRAC_W);

   typedef logic signed [SMP_W-1:0] sample_type;
   typedef logic signed [ACC_W-1:0] acc_type;
   typedef logic [DLY_W-1:0]        delay_type;

   localparam acc_type SAT_HI = acc_type'((1 << (SMP_W - 1)) - 1);
   localparam acc_type SAT_LO = -acc_type'(1 << (SMP_W - 1));

   // tap slots around the read point
   localparam logic [1:0] TAP_YM1 = 2'd0;
   localparam logic [1:0] TAP_Y0  = 2'd1;
   localparam logic [1:0] TAP_Y1  = 2'd2;
   localparam logic [1:0] TAP_Y2  = 2'd3;

   // lane operations
   localparam logic [2:0] OP_NONE = 3'd0;
   localparam logic [2:0] OP_COEF = 3'd1;
   localparam logic [2:0] OP_H1   = 3'd2;
   localparam logic [2:0] OP_H2   = 3'd3;
   localparam logic [2:0] OP_H3   = 3'd4;

   typedef struct packed {
      logic       tap_load;
      logic [1:0] tap_sel;
      logic [2:0] op;
   } lane_ctl_type;

endpackage

`default_nettype wire

// File: rtl/core/hfdl_req_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface hfdl_req_if import hfdl_pkg::*; ();
   logic       valid;
   logic       ready;
   sample_type in_first;
   sample_type in_second;
   delay_type  delay_amount;

   modport source (output valid, in_first, in_second, delay_amount, input ready);
   modport sink   (input valid, in_first, in_second, delay_amount, output ready);
endinterface

`default_nettype wire

// File: rtl/core/hfdl_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface hfdl_rsp_if import hfdl_pkg::*; ();
   logic       valid;
   logic       ready;
   sample_type out_first;
   sample_type out_second;

   modport source (output valid, out_first, out_second, input ready);
   modport sink   (input valid, out_first, out_second, output ready);
endinterface

`default_nettype wire

// File: rtl/core/hfdl_store.sv
`timescale 1ns / 1ps
`default_nettype none

module hfdl_store import hfdl_pkg::*; (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [AW-1:0]     wr_addr,
   input  wire logic [WORD_W-1:0] wr_data,
   input  wire logic              rd_en,
   input  wire logic [AW-1:0]     rd_addr,
   output logic [WORD_W-1:0]      rd_data
);

   logic [WORD_W-1:0] mem_ff [DEPTH];
   logic [WORD_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: rtl/core/hfdl_lane.sv
`timescale 1ns / 1ps
`default_nettype none

module hfdl_lane import hfdl_pkg::*; (
   input  wire logic              clock,
   input  wire lane_ctl_type      ctl,
   input  wire logic [FRAC_W-1:0] frac,
   input  wire sample_type        tap_data,
   output sample_type             result
);

   localparam int PROD_W = ACC_W + FRAC_W + 1;
   localparam logic signed [PROD_W-1:0] RND_HALF = PROD_W'(1 << (FRAC_W - 1));

   sample_type taps_ff [4];
   acc_type    k1_ff;
   acc_type    k2_ff;
   acc_type    k3_ff;
   acc_type    acc_ff;

   acc_type                  ym1;
   acc_type                  y0;
   acc_type                  y1;
   acc_type                  y2;
   acc_type                  mul_a;
   acc_type                  addend;
   logic signed [FRAC_W:0]   frac_s;
   logic signed [PROD_W-1:0] prod;
   logic signed [PROD_W-1:0] prod_rnd;
   acc_type                  step;
   acc_type                  sum;

   assign ym1 = acc_type'(taps_ff[TAP_YM1]);
   assign y0  = acc_type'(taps_ff[TAP_Y0]);
   assign y1  = acc_type'(taps_ff[TAP_Y1]);
   assign y2  = acc_type'(taps_ff[TAP_Y2]);

   always_ff @(posedge clock) begin
      if (ctl.tap_load) begin
         taps_ff[ctl.tap_sel] <= tap_data;
      end
   end

   // one multiplier shared by the three Horner steps
   always_comb begin
      mul_a  = acc_ff;
      addend = '0;
      case (ctl.op)
         OP_H1: begin
            mul_a  = k3_ff;
            addend = k2_ff;
         end
         OP_H2: begin
            addend = k1_ff;
         end
         default: begin
            addend = '0;
         end
      endcase
      frac_s   = $signed({1'b0, frac});
      prod     = PROD_W'(mul_a) * PROD_W'(frac_s);
      prod_rnd = (prod + RND_HALF) >>> FRAC_W;
      step     = acc_type'(prod_rnd) + addend;
   end

   always_ff @(posedge clock) begin
      case (ctl.op)
         OP_COEF: begin
            k1_ff <= y1 - ym1;
            k2_ff <= (ym1 <<< 1) - ((y0 <<< 2) + y0) + (y1 <<< 2) - y2;
            k3_ff <= (y2 - ym1) + (((y0 - y1) <<< 1) + (y0 - y1));
         end
         OP_H1, OP_H2, OP_H3: begin
            acc_ff <= step;
         end
         default: begin
            acc_ff <= acc_ff;
         end
      endcase
   end

   // add half the doubled curve term to the center tap, then clip
   always_comb begin
      sum = y0 + ((acc_ff + acc_type'(1)) >>> 1);
      if (sum > SAT_HI) begin
         result = SAT_HI[SMP_W-1:0];
      end else if (sum < SAT_LO) begin
         result = SAT_LO[SMP_W-1:0];
      end else begin
         result = sum[SMP_W-1:0];
      end
   end

endmodule

`default_nettype wire

// File: rtl/core/hermite_fractional_delay_line.sv
`timescale 1ns / 1ps
`default_nettype none

// Items are handled one at a time: a new item is accepted only after the last result
// is loaded. Each item goes through the accept, the store write, four serial reads
// through the one read port of the sample store, a drain, the coefficients, the three
// multiply steps of the Horner loop and the output load, which waits on a held result.
// Reset: synchronous; clears the write position, the wrap flag and the handshake state.
// The store is not swept: entries not yet written since reset read as zero.
module hermite_fractional_delay_line import hfdl_pkg::*; (
   input wire logic  clock,
   input wire logic  reset,
   hfdl_req_if.sink  req,
   hfdl_rsp_if.source rsp
);

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_WRITE = 4'd1;
   localparam logic [3:0] ST_READ  = 4'd2;
   localparam logic [3:0] ST_DRAIN = 4'd3;
   localparam logic [3:0] ST_COEF  = 4'd4;
   localparam logic [3:0] ST_H1    = 4'd5;
   localparam logic [3:0] ST_H2    = 4'd6;
   localparam logic [3:0] ST_H3    = 4'd7;
   localparam logic [3:0] ST_OUT   = 4'd8;

   logic [3:0]       state_ff, state_in;
   logic [AW-1:0]    wp_ff, wp_in;
   logic             wrapped_ff, wrapped_in;
   logic [1:0]       tap_cnt_ff, tap_cnt_in;
   logic             rd_pend_ff, rd_pend_in;
   logic [1:0]       rd_tap_ff;
   logic             rd_live_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [POS_W-1:0] pos_ff;
   sample_type       first_ff;
   sample_type       second_ff;
   delay_type        delay_ff;
   sample_type       out_first_ff;
   sample_type       out_second_ff;

   logic              accept;
   logic              rsp_load;
   delay_type         delay_cl;
   logic [AW-1:0]     rd_addr;
   logic              rd_live;
   logic              mem_we;
   logic              mem_re;
   logic [WORD_W-1:0] rd_data;
   lane_ctl_type      lane_ctl;
   logic [2:0]        lane_op;
   sample_type        lane_out [LANES];

   assign accept   = req.valid && req.ready;
   assign rsp_load = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp.ready);
   assign mem_we   = (state_ff == ST_WRITE);
   assign mem_re   = (state_ff == ST_READ);

   assign req.ready      = (state_ff == ST_IDLE);
   assign rsp.valid      = rsp_valid_ff;
   assign rsp.out_first  = out_first_ff;
   assign rsp.out_second = out_second_ff;

   // clamp the delay and wrap the read position
   always_comb begin
      if (delay_ff < DLY_MIN) begin
         delay_cl = DLY_MIN;
      end else if (delay_ff > DLY_MAX) begin
         delay_cl = DLY_MAX;
      end else begin
         delay_cl = delay_ff;
      end
   end

   // taps run from one before the integer part to two after it
   assign rd_addr = pos_ff[POS_W-1:FRAC_W] + AW'(tap_cnt_ff) - AW'(1);
   assign rd_live = wrapped_ff || (rd_addr <= wp_ff);

   always_comb begin
      state_in     = state_ff;
      wp_in        = wp_ff;
      wrapped_in   = wrapped_ff;
      tap_cnt_in   = tap_cnt_ff;
      rd_pend_in   = mem_re;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      lane_op      = OP_NONE;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            tap_cnt_in = '0;
            state_in   = ST_READ;
         end
         ST_READ: begin
            tap_cnt_in = tap_cnt_ff + 2'd1;
            if (tap_cnt_ff == 2'd3) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_COEF;
         end
         ST_COEF: begin
            lane_op  = OP_COEF;
            state_in = ST_H1;
         end
         ST_H1: begin
            lane_op  = OP_H1;
            state_in = ST_H2;
         end
         ST_H2: begin
            lane_op  = OP_H2;
            state_in = ST_H3;
         end
         ST_H3: begin
            lane_op  = OP_H3;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (rsp_load) begin
               rsp_valid_in = 1'b1;
               wp_in        = wp_ff + AW'(1);
               if (wp_ff == AW'(DEPTH - 1)) begin
                  wrapped_in = 1'b1;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wp_ff        <= '0;
         wrapped_ff   <= 1'b0;
         tap_cnt_ff   <= '0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wp_ff        <= wp_in;
         wrapped_ff   <= wrapped_in;
         tap_cnt_ff   <= tap_cnt_in;
         rd_pend_ff   <= rd_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         first_ff  <= req.in_first;
         second_ff <= req.in_second;
         delay_ff  <= req.delay_amount;
      end
      if (state_ff == ST_WRITE) begin
         pos_ff <= POS_W'({wp_ff, FRAC_W'(0)}) - POS_W'(delay_cl);
      end
      rd_tap_ff  <= tap_cnt_ff;
      rd_live_ff <= rd_live;
      if (rsp_load) begin
         out_first_ff  <= lane_out[0];
         out_second_ff <= lane_out[1];
      end
   end

   hfdl_store u_store (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (wp_ff),
      .wr_data ({second_ff, first_ff}),
      .rd_en   (mem_re),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign lane_ctl.tap_load = rd_pend_ff;
   assign lane_ctl.tap_sel  = rd_tap_ff;
   assign lane_ctl.op       = lane_op;

   for (genvar ln = 0; ln < LANES; ln++) begin : g_lane
      sample_type tap_word;

      // drop taps from entries not yet written since reset
      assign tap_word = rd_live_ff ? rd_data[ln*SMP_W +: SMP_W] : '0;

      hfdl_lane u_lane (
         .clock    (clock),
         .ctl      (lane_ctl),
         .frac     (pos_ff[FRAC_W-1:0]),
         .tap_data (tap_word),
         .result   (lane_out[ln])
      );
   end

   a_accept_to_write: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == ST_WRITE)
      else $error("accepted item did not start a store write");

   a_wp_advance: assert property (@(posedge clock) disable iff (reset)
      rsp_load |=> wp_ff == $past(wp_ff) + AW'(1))
      else $error("write position did not advance with the result");

   a_wrap_sticky: assert property (@(posedge clock) disable iff (reset)
      wrapped_ff |=> wrapped_ff)
      else $error("wrap flag cleared outside reset");

   a_read_follows_write: assert property (@(posedge clock) disable iff (reset)
      mem_we |=> mem_re && tap_cnt_ff == 2'd0)
      else $error("tap reads did not follow the store write");

   a_no_accept_while_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !req.ready)
      else $error("input ready while an item is in progress");

endmodule

`default_nettype wire

// File: test/tb.sv
`timescale 1ns / 1ps

module tb;
   import hfdl_pkg::*;

   typedef struct {
      sample_type first;
      sample_type second;
      delay_type  dly;
   } stereo_in_type;

   typedef struct {
      sample_type first;
      sample_type second;
   } stereo_out_type;

   logic clock;
   logic reset;

   hfdl_req_if req_bus ();
   hfdl_rsp_if rsp_bus ();

   hermite_fractional_delay_line u_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_bus),
      .rsp   (rsp_bus)
   );

   sample_type     hist_store [2][DEPTH];
   int             write_pos;
   stereo_out_type delayed_frames [$];
   int             mismatch_count;
   int             frames_sent;
   bit             send_gaps_on;
   bit             rsp_stall_on;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #40_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   function automatic longint round_shift(longint x, int s);
      return (x + (longint'(1) <<< (s - 1))) >>> s;
   endfunction

   function automatic sample_type hermite_read(int lane, longint pos);
      longint idx, f, ym1, y0, y1, y2, k1, k2, k3, t, r;
      idx = pos >>> FRAC_W;
      f   = pos & 64'hFFFF;
      ym1 = hist_store[lane][int'((idx - 1) & (DEPTH - 1))];
      y0  = hist_store[lane][int'(idx & (DEPTH - 1))];
      y1  = hist_store[lane][int'((idx + 1) & (DEPTH - 1))];
      y2  = hist_store[lane][int'((idx + 2) & (DEPTH - 1))];
      k1  = y1 - ym1;
      k2  = 2 * ym1 - 5 * y0 + 4 * y1 - y2;
      k3  = (y2 - ym1) + 3 * (y0 - y1);
      t   = round_shift(k3 * f, FRAC_W) + k2;
      t   = round_shift(t * f, FRAC_W) + k1;
      t   = round_shift(t * f, FRAC_W);
      r   = y0 + round_shift(t, 1);
      if (r > longint'(SAT_HI)) r = longint'(SAT_HI);
      if (r < longint'(SAT_LO)) r = longint'(SAT_LO);
      return sample_type'(r);
   endfunction

   function automatic stereo_out_type delay_line_step(stereo_in_type fr);
      stereo_out_type res;
      longint d, pos;
      d = longint'(fr.dly);
      if (d < (longint'(2) << FRAC_W)) d = longint'(2) << FRAC_W;
      if (d > (longint'(DEPTH - 4) << FRAC_W)) d = longint'(DEPTH - 4) << FRAC_W;
      pos = (longint'(write_pos) << FRAC_W) - d;
      if (pos < 0) pos += longint'(DEPTH) << FRAC_W;
      hist_store[0][write_pos] = fr.first;
      hist_store[1][write_pos] = fr.second;
      res.first  = hermite_read(0, pos);
      res.second = hermite_read(1, pos);
      write_pos  = (write_pos + 1) % DEPTH;
      return res;
   endfunction

   function automatic sample_type rand_sample();
      case ($urandom_range(0, 9))
         0: return sample_type'(24'h7FFFFF);
         1: return sample_type'(24'h800000);
         2: return sample_type'(int'($urandom_range(0, 2000)) - 1000);
         default: return sample_type'($urandom);
      endcase
   endfunction

   function automatic delay_type rand_delay();
      case ($urandom_range(0, 9))
         0: return delay_type'($urandom);
         1: return delay_type'($urandom_range(32'h0, 32'h8_0000));
         2: return delay_type'($urandom_range(2, DEPTH - 4) << FRAC_W);
         3: return DLY_MAX - delay_type'($urandom_range(0, 16 << FRAC_W));
         default: return delay_type'($urandom_range(DLY_MIN, DLY_MAX));
      endcase
   endfunction

   // enter and leave at a rising edge; valid stays high on return
   task automatic send_frame(stereo_in_type fr);
      int gap;
      gap = 0;
      if (send_gaps_on && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 15);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.in_first     <= fr.first;
      req_bus.in_second    <= fr.second;
      req_bus.delay_amount <= fr.dly;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      delayed_frames.push_back(delay_line_step(fr));
      frames_sent++;
   endtask

   task automatic drain_results();
      req_bus.valid <= 1'b0;
      while (delayed_frames.size() != 0) @(posedge clock);
   endtask

   task automatic test_delay_clamp();
      delay_type probes [$];
      probes.push_back(delay_type'(0));
      probes.push_back(delay_type'(1 << FRAC_W));
      probes.push_back(delay_type'(DLY_MIN - 1));
      probes.push_back(DLY_MIN);
      probes.push_back(delay_type'(DLY_MIN + 1));
      probes.push_back(DLY_MAX);
      probes.push_back(delay_type'(DLY_MAX + 1));
      probes.push_back(delay_type'(28'hFFFFFFF));
      probes.push_back(delay_type'((5 << FRAC_W) | 16'hFFFF));
      foreach (probes[i])
         send_frame('{rand_sample(), rand_sample(), probes[i]});
      drain_results();
   endtask

   // at the smallest delay the newest tap is the item just written
   task automatic test_newest_tap();
      send_frame('{sample_type'(24'h7FFFFF), sample_type'(24'h800000), DLY_MIN});
      send_frame('{sample_type'(24'h800000), sample_type'(24'h7FFFFF), DLY_MIN});
      send_frame('{sample_type'(24'h123456), sample_type'(24'hEDCBA9), DLY_MIN + 16'h8000});
      send_frame('{sample_type'(24'h7FFFFF), sample_type'(24'h000001), DLY_MIN + 16'h0001});
      drain_results();
   endtask

   // alternate full-scale pairs so the cubic overshoots both rails
   task automatic test_overshoot();
      sample_type hi_lo;
      for (int k = 0; k < 12; k++) begin
         hi_lo = (k % 4 == 1 || k % 4 == 2) ? sample_type'(24'h7FFFFF)
                                            : sample_type'(24'h800000);
         send_frame('{hi_lo, ~hi_lo, delay_type'(((k % 2) ? 7 : 5) << (FRAC_W - 1))});
      end
      drain_results();
   endtask

   task automatic test_random_frames();
      for (int i = 0; i < 1200; i++) begin
         if (i % 150 == 0) begin
            send_gaps_on = $urandom_range(0, 2) != 0;
            rsp_stall_on = $urandom_range(0, 2) != 0;
         end
         if (i == 600) drain_results();
         send_frame('{rand_sample(), rand_sample(), rand_delay()});
      end
      drain_results();
   endtask

   // keep the delay near its maximum for most items at full rate so the taps land on the
   // oldest entries, unwritten ones included
   task automatic test_far_taps();
      delay_type dly;
      send_gaps_on = 1'b0;
      rsp_stall_on = 1'b0;
      while (frames_sent < 1800) begin
         if ($urandom_range(0, 3) != 0) dly = DLY_MAX - delay_type'($urandom_range(0, 16 << FRAC_W));
         else dly = rand_delay();
         send_frame('{rand_sample(), rand_sample(), dly});
      end
      drain_results();
   endtask

   initial begin
      int stall_left;
      stall_left = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (stall_left > 0) begin
            stall_left--;
            rsp_bus.ready <= 1'b0;
         end else if (rsp_stall_on && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 15) - 1;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   initial begin
      stereo_out_type want;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
            if (delayed_frames.size() == 0) begin
               $error("unexpected item: out_first %0d out_second %0d",
                      rsp_bus.out_first, rsp_bus.out_second);
               mismatch_count++;
            end else begin
               want = delayed_frames.pop_front();
               if (rsp_bus.out_first !== want.first) begin
                  $error("out_first: expected %0d, actual %0d", want.first, rsp_bus.out_first);
                  mismatch_count++;
               end
               if (rsp_bus.out_second !== want.second) begin
                  $error("out_second: expected %0d, actual %0d",
                         want.second, rsp_bus.out_second);
                  mismatch_count++;
               end
            end
         end
      end
   end

   initial begin
      mismatch_count = 0;
      frames_sent    = 0;
      write_pos      = 0;
      send_gaps_on   = 1'b1;
      rsp_stall_on   = 1'b1;
      foreach (hist_store[l, a]) hist_store[l][a] = '0;
      reset                <= 1'b1;
      req_bus.valid        <= 1'b0;
      req_bus.in_first     <= '0;
      req_bus.in_second    <= '0;
      req_bus.delay_amount <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_delay_clamp();
      test_newest_tap();
      test_overshoot();
      test_random_frames();
      test_far_taps();
      repeat (24) @(posedge clock);
      if (mismatch_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
